@@ sv/tblo_pkg.sv @@
// Shared types, constants and helper functions of the tile-binned layer order table.
package tblo_pkg;

   localparam int MaxLayers = 32;
   localparam int GridX     = 8;
   localparam int GridY     = 8;
   localparam int CoordBits = 16;
   localparam int Tiles     = GridX * GridY;
   localparam int TileBits  = $clog2(Tiles);
   localparam int DepthBits = $clog2(MaxLayers);
   localparam int CountBits = $clog2(MaxLayers + 1);
   localparam int GxBits    = (GridX > 1) ? $clog2(GridX) : 1;
   localparam int GyBits    = (GridY > 1) ? $clog2(GridY) : 1;
   localparam int DivBits   = 17;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_MOVE   = 3'd2;
   localparam logic [2:0] CMD_REPOS  = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;
   localparam logic [2:0] CMD_READ   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [1:0] REG_CANVAS_W = 2'd0;
   localparam logic [1:0] REG_CANVAS_H = 2'd1;
   localparam logic [1:0] REG_TILE_W   = 2'd2;
   localparam logic [1:0] REG_TILE_H   = 2'd3;

   typedef struct packed {
      logic              placed;
      logic [GxBits-1:0] x0;
      logic [GxBits-1:0] x1;
      logic [GyBits-1:0] y0;
      logic [GyBits-1:0] y1;
   } span_type;

   // Insert bit b at position pos, shifting higher bits up.
   function automatic logic [MaxLayers-1:0] bit_ins(logic [MaxLayers-1:0] bm,
                                                    logic [CountBits-1:0] pos,
                                                    logic b);
      logic [MaxLayers-1:0] lo_m;
      logic [MaxLayers-1:0] r;
      lo_m = (pos >= CountBits'(MaxLayers)) ? '1 : ~({MaxLayers{1'b1}} << pos);
      r = (bm & lo_m) | ((bm & ~lo_m) << 1);
      if (pos < CountBits'(MaxLayers))
         r[pos[DepthBits-1:0]] = b;
      return r;
   endfunction

   // Remove the bit at position pos, shifting higher bits down.
   function automatic logic [MaxLayers-1:0] bit_rem(logic [MaxLayers-1:0] bm,
                                                    logic [CountBits-1:0] pos);
      logic [MaxLayers-1:0] lo_m;
      lo_m = (pos >= CountBits'(MaxLayers)) ? '1 : ~({MaxLayers{1'b1}} << pos);
      return (bm & lo_m) | ((bm >> 1) & ~lo_m);
   endfunction

endpackage

@@ sv/tblo_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface tblo_req_if
   import tblo_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [2:0]           command;
   logic [5:0]           layer_index;
   logic [4:0]           target_index;
   logic signed [15:0]   origin_x;
   logic signed [15:0]   origin_y;
   logic [15:0]          layer_width;
   logic [15:0]          layer_height;
   logic [2:0]           cell_x;
   logic [2:0]           cell_y;
   modport source (output valid, command, layer_index, target_index, origin_x, origin_y,
                   layer_width, layer_height, cell_x, cell_y, input ready);
   modport sink   (input valid, command, layer_index, target_index, origin_x, origin_y,
                   layer_width, layer_height, cell_x, cell_y, output ready);
endinterface

interface tblo_rsp_if
   import tblo_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  layer_count;
   logic        in_grid;
   logic [2:0]  min_tile_x;
   logic [2:0]  max_tile_x;
   logic [2:0]  min_tile_y;
   logic [2:0]  max_tile_y;
   logic [31:0] cell_layers;
   modport source (output valid, status, layer_count, in_grid, min_tile_x, max_tile_x,
                   min_tile_y, max_tile_y, cell_layers, input ready);
   modport sink   (input valid, status, layer_count, in_grid, min_tile_x, max_tile_x,
                   min_tile_y, max_tile_y, cell_layers, output ready);
endinterface

@@ sv/tile_binned_layer_order_table.sv @@
// Top level of the tile-binned layer order table.
//
// Requests arrive on req (valid/ready); one response per request leaves on rsp.
// The user must see that configuration registers are written on csr_* only while
// the block is idle; the block itself does not enforce this. Each request is
// handled alone. Insert and reposition first divide the canvas and the clamped
// coordinates by the tile sizes in six divisions on a bit-serial divider. Every
// editing command then walks all 64 tile bitmaps through a registered-read tile
// memory, reading one tile and writing the previous one back each cycle. Layer
// spans are kept in a 32-entry memory that is shifted one entry at a time, with
// a read and then a write, for insert, remove and move. The next request is
// accepted in the cycle after the response transfer at the earliest.
// After reset a clearing pass zeroes the tile memory; no request is taken until
// it ends. The response is held in an output register while the receiver stalls,
// and the input stays blocked until then.
module tile_binned_layer_order_table
   import tblo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tblo_req_if.sink      req,
   tblo_rsp_if.source    rsp,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data
);

   typedef enum logic [8:0] {
      S_WIPE  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_DIV   = 9'b000000100,
      S_OLD   = 9'b000001000,
      S_SHIFT = 9'b000010000,
      S_WALK  = 9'b000100000,
      S_RD    = 9'b001000000,
      S_RDW   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] cw_ff, ch_ff, tw_ff, th_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= 16'd640; ch_ff <= 16'd480; tw_ff <= 16'd80; th_ff <= 16'd60;
      end else if (csr_write) begin
         case (csr_index)
            REG_CANVAS_W: cw_ff <= csr_data;
            REG_CANVAS_H: ch_ff <= csr_data;
            REG_TILE_W:   tw_ff <= csr_data;
            REG_TILE_H:   th_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Latched request.
   logic [2:0]           cmd_ff;
   logic [CountBits-1:0] idx_ff, tgt_ff;
   logic [2:0]           cx_ff, cy_ff;
   logic [CountBits-1:0] cnt_ff, cnt_in;
   span_type             new_ff, new_in, old_ff, old_in;
   logic signed [15:0]   ox_ff, oy_ff;
   logic [15:0]          w_ff, h_ff;

   // Division operands: six quotients are needed.
   logic signed [17:0] mnx, mxx, mny, mxy;
   logic [16:0]        lox, hix, loy, hiy;
   logic               geo_ok;
   logic [2:0]         dstep_ff, dstep_in;
   logic [DivBits-1:0] q_ff [6];
   logic               dstart_ff, dstart_in;
   logic [DivBits-1:0] dvd;
   logic [15:0]        dvs;
   logic               ddone;
   logic [DivBits-1:0] dq;

   always_comb begin
      mnx = {{2{ox_ff[15]}}, ox_ff} - 18'({1'b0, w_ff[15:1]});
      mxx = {{2{ox_ff[15]}}, ox_ff} + 18'({1'b0, w_ff[15:1]});
      mny = {{2{oy_ff[15]}}, oy_ff} - 18'({1'b0, h_ff[15:1]});
      mxy = {{2{oy_ff[15]}}, oy_ff} + 18'({1'b0, h_ff[15:1]});
      geo_ok = (w_ff != 0) && (h_ff != 0) && (tw_ff != 0) && (th_ff != 0)
               && !mxx[17] && !mxy[17]
               && !(mnx > $signed({2'b0, cw_ff})) && !(mny > $signed({2'b0, ch_ff}));
      lox = mnx[17] ? 17'd0 : mnx[16:0];
      loy = mny[17] ? 17'd0 : mny[16:0];
      hix = (mxx > $signed({2'b0, cw_ff})) ? {1'b0, cw_ff} : mxx[16:0];
      hiy = (mxy > $signed({2'b0, ch_ff})) ? {1'b0, ch_ff} : mxy[16:0];
      case (dstep_ff)
         3'd0: begin dvd = {1'b0, cw_ff}; dvs = tw_ff; end
         3'd1: begin dvd = {1'b0, ch_ff}; dvs = th_ff; end
         3'd2: begin dvd = (lox == 0) ? 17'd0 : 17'(lox - 17'd1); dvs = tw_ff; end
         3'd3: begin dvd = (hix == 0) ? 17'd0 : 17'(hix - 17'd1); dvs = tw_ff; end
         3'd4: begin dvd = (loy == 0) ? 17'd0 : 17'(loy - 17'd1); dvs = th_ff; end
         default: begin dvd = (hiy == 0) ? 17'd0 : 17'(hiy - 17'd1); dvs = th_ff; end
      endcase
   end

   tblo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart_ff),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (ddone),
      .quotient (dq)
   );

   // Span from the quotients.
   logic [DivBits-1:0] nx, ny;
   span_type           calc;
   always_comb begin
      nx = (q_ff[0] > DivBits'(GridX)) ? DivBits'(GridX) : q_ff[0];
      ny = (q_ff[1] > DivBits'(GridY)) ? DivBits'(GridY) : q_ff[1];
      calc = '0;
      if (geo_ok && nx != 0 && ny != 0 && q_ff[2] < nx && q_ff[3] < nx
          && q_ff[4] < ny && q_ff[5] < ny) begin
         calc.placed = 1'b1;
         calc.x0 = q_ff[2][GxBits-1:0];
         calc.x1 = q_ff[3][GxBits-1:0];
         calc.y0 = q_ff[4][GyBits-1:0];
         calc.y1 = q_ff[5][GyBits-1:0];
      end
   end

   // Span memory (one write, one read, registered read data).
   span_type             span_mem [MaxLayers];
   span_type             sp_rd_ff;
   logic [DepthBits-1:0] sp_ra, sp_wa;
   logic                 sp_we;
   span_type             sp_wd;
   always_ff @(posedge clock) begin
      if (sp_we)
         span_mem[sp_wa] <= sp_wd;
      sp_rd_ff <= span_mem[sp_ra];
   end

   // Tile memory.
   logic [MaxLayers-1:0] tile_mem [Tiles];
   logic [MaxLayers-1:0] tm_rd_ff;
   logic [TileBits-1:0]  tm_ra, tm_wa;
   logic                 tm_we;
   logic [MaxLayers-1:0] tm_wd;
   always_ff @(posedge clock) begin
      if (tm_we)
         tile_mem[tm_wa] <= tm_wd;
      tm_rd_ff <= tile_mem[tm_ra];
   end

   // Walk and shift counters.
   logic [TileBits:0]  wk_ff, wk_in;
   logic [CountBits:0] sh_ff, sh_in;
   logic               shp_ff, shp_in;
   logic               st_ff, st_in;
   logic               okcmd;

   // Response register.
   logic [1:0]           rs_st_ff, rs_st_in;
   span_type             rs_sp_ff, rs_sp_in;
   logic [MaxLayers-1:0] rs_cl_ff, rs_cl_in;

   // Tile under the previous walk read.
   logic [TileBits-1:0]  pt;
   logic [GxBits-1:0]    ptx;
   logic [GyBits-1:0]    pty;
   logic                 in_old, in_new;
   logic [MaxLayers-1:0] bm;

   always_comb begin
      pt  = wk_ff[TileBits-1:0] - TileBits'(1);
      ptx = GxBits'(pt % GridX);
      pty = GyBits'(pt / GridX);
      in_old = old_ff.placed && ptx >= old_ff.x0 && ptx <= old_ff.x1
               && pty >= old_ff.y0 && pty <= old_ff.y1;
      in_new = new_ff.placed && ptx >= new_ff.x0 && ptx <= new_ff.x1
               && pty >= new_ff.y0 && pty <= new_ff.y1;
      bm = tm_rd_ff;
      case (cmd_ff)
         CMD_INSERT: bm = bit_ins(tm_rd_ff, idx_ff, in_new);
         CMD_REMOVE: bm = bit_rem(tm_rd_ff, idx_ff);
         CMD_MOVE:   bm = bit_ins(bit_rem(tm_rd_ff, idx_ff), tgt_ff,
                                  tm_rd_ff[idx_ff[DepthBits-1:0]]);
         CMD_REPOS: begin
            if (in_old) bm[idx_ff[DepthBits-1:0]] = 1'b0;
            if (in_new) bm[idx_ff[DepthBits-1:0]] = 1'b1;
         end
         default:    bm = '0;
      endcase
   end

   // Main sequencer.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      new_in    = new_ff;
      old_in    = old_ff;
      dstep_in  = dstep_ff;
      dstart_in = 1'b0;
      wk_in     = wk_ff;
      sh_in     = sh_ff;
      shp_in    = shp_ff;
      st_in     = st_ff;
      rs_st_in  = rs_st_ff;
      rs_sp_in  = rs_sp_ff;
      rs_cl_in  = rs_cl_ff;
      tm_ra = wk_ff[TileBits-1:0];
      tm_we = 1'b0;
      tm_wa = pt;
      tm_wd = bm;
      sp_ra = idx_ff[DepthBits-1:0];
      sp_we = 1'b0;
      sp_wa = idx_ff[DepthBits-1:0];
      sp_wd = new_ff;
      okcmd = 1'b0;
      req.ready = (state_ff == S_IDLE);
      case (state_ff)
         S_WIPE: begin
            tm_we = 1'b1;
            tm_wa = wk_ff[TileBits-1:0];
            tm_wd = '0;
            wk_in = wk_ff + 1'b1;
            if (wk_ff == (TileBits+1)'(Tiles - 1))
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               rs_sp_in = '0;
               rs_cl_in = '0;
               rs_st_in = ST_OK;
               dstep_in = '0;
               wk_in    = '0;
               new_in   = '0;
               case (req.command)
                  CMD_INSERT: okcmd = (req.layer_index <= cnt_ff)
                                      && (cnt_ff < CountBits'(MaxLayers));
                  CMD_REMOVE: okcmd = (req.layer_index < cnt_ff);
                  CMD_MOVE:   okcmd = (req.layer_index < cnt_ff)
                                      && ({1'b0, req.target_index} < cnt_ff);
                  CMD_REPOS:  okcmd = (req.layer_index < cnt_ff);
                  default:    okcmd = 1'b1;
               endcase
               if (!okcmd) begin
                  rs_st_in = (req.command == CMD_INSERT && req.layer_index <= cnt_ff)
                             ? ST_FULL : ST_INDEX;
                  state_in = S_OUT;
               end else begin
                  case (req.command)
                     CMD_INSERT, CMD_REPOS: begin
                        dstart_in = 1'b1;
                        state_in  = S_DIV;
                     end
                     CMD_REMOVE, CMD_MOVE: state_in = S_OLD;
                     CMD_CLEAR: begin
                        cnt_in   = '0;
                        state_in = S_WALK;
                     end
                     CMD_READ: state_in = S_RD;
                     default:  state_in = S_OUT;
                  endcase
               end
            end
         end
         S_DIV: begin
            if (ddone) begin
               dstep_in = dstep_ff + 3'd1;
               if (dstep_ff == 3'd5) begin
                  state_in = S_OLD;
               end else begin
                  dstart_in = 1'b1;
               end
            end
         end
         S_OLD: begin
            // Span of the indexed layer arrives from the span memory.
            if (!st_ff) begin
               st_in = 1'b1;
               if (cmd_ff == CMD_INSERT) begin
                  new_in = calc;
                  old_in = '0;
                  st_in  = 1'b0;
                  sh_in  = (CountBits+1)'(cnt_ff);
                  shp_in = 1'b0;
                  state_in = S_SHIFT;
               end
            end else begin
               st_in = 1'b0;
               old_in = sp_rd_ff;
               rs_sp_in = sp_rd_ff;
               if (cmd_ff == CMD_REPOS) begin
                  new_in   = calc;
                  rs_sp_in = calc;
                  sp_we    = 1'b1;
                  sp_wd    = calc;
                  state_in = S_WALK;
               end else begin
                  new_in = sp_rd_ff;
                  sh_in  = (CountBits+1)'(idx_ff);
                  shp_in = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // Span list moves one entry at a time (read, then write).
            case (cmd_ff)
               CMD_INSERT: begin
                  sp_ra = sh_ff[DepthBits-1:0] - DepthBits'(1);
                  if (sh_ff[CountBits-1:0] == idx_ff) begin
                     sp_we = 1'b1;
                     sp_wa = idx_ff[DepthBits-1:0];
                     sp_wd = new_ff;
                     rs_sp_in = new_ff;
                     cnt_in = cnt_ff + 1'b1;
                     state_in = S_WALK;
                  end else if (!shp_ff) begin
                     shp_in = 1'b1;
                  end else begin
                     sp_we = 1'b1;
                     sp_wa = sh_ff[DepthBits-1:0];
                     sp_wd = sp_rd_ff;
                     shp_in = 1'b0;
                     sh_in = sh_ff - 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  sp_ra = sh_ff[DepthBits-1:0] + DepthBits'(1);
                  if (sh_ff + 1'b1 >= (CountBits+1)'(cnt_ff)) begin
                     cnt_in = cnt_ff - 1'b1;
                     state_in = S_WALK;
                  end else if (!shp_ff) begin
                     shp_in = 1'b1;
                  end else begin
                     sp_we = 1'b1;
                     sp_wa = sh_ff[DepthBits-1:0];
                     sp_wd = sp_rd_ff;
                     shp_in = 1'b0;
                     sh_in = sh_ff + 1'b1;
                  end
               end
               default: begin
                  // Move: shift towards the target, then drop the span there.
                  if (sh_ff[CountBits-1:0] == tgt_ff) begin
                     sp_we = 1'b1;
                     sp_wa = tgt_ff[DepthBits-1:0];
                     sp_wd = new_ff;
                     state_in = S_WALK;
                  end else begin
                     sp_ra = (tgt_ff > idx_ff) ? sh_ff[DepthBits-1:0] + DepthBits'(1)
                                               : sh_ff[DepthBits-1:0] - DepthBits'(1);
                     if (!shp_ff) begin
                        shp_in = 1'b1;
                     end else begin
                        sp_we = 1'b1;
                        sp_wa = sh_ff[DepthBits-1:0];
                        sp_wd = sp_rd_ff;
                        shp_in = 1'b0;
                        sh_in = (tgt_ff > idx_ff) ? sh_ff + 1'b1 : sh_ff - 1'b1;
                     end
                  end
               end
            endcase
         end
         S_WALK: begin
            // Read tile wk, write back tile wk-1.
            tm_we = (wk_ff != '0);
            wk_in = wk_ff + 1'b1;
            if (wk_ff == (TileBits+1)'(Tiles))
               state_in = S_OUT;
         end
         S_RD: begin
            tm_ra = TileBits'(cy_ff * GridX + cx_ff);
            state_in = S_RDW;
         end
         S_RDW: begin
            if (({1'b0, cx_ff} >= 4'(GridX)) || ({1'b0, cy_ff} >= 4'(GridY)))
               rs_st_in = ST_INDEX;
            else
               rs_cl_in = tm_rd_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Quotient capture.
   always_ff @(posedge clock) begin
      if (ddone && state_ff == S_DIV)
         q_ff[dstep_ff] <= dq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_WIPE;
         cnt_ff    <= '0;
         wk_ff     <= '0;
         dstart_ff <= 1'b0;
         st_ff     <= 1'b0;
         shp_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         wk_ff     <= wk_in;
         dstart_ff <= dstart_in;
         st_ff     <= st_in;
         shp_ff    <= shp_in;
      end
      dstep_ff <= dstep_in;
      sh_ff    <= sh_in;
      new_ff   <= new_in;
      old_ff   <= old_in;
      rs_st_ff <= rs_st_in;
      rs_sp_ff <= rs_sp_in;
      rs_cl_ff <= rs_cl_in;
      if (req.valid && req.ready) begin
         cmd_ff <= req.command;
         idx_ff <= req.layer_index;
         tgt_ff <= CountBits'(req.target_index);
         cx_ff  <= req.cell_x;
         cy_ff  <= req.cell_y;
         ox_ff  <= req.origin_x;
         oy_ff  <= req.origin_y;
         w_ff   <= req.layer_width;
         h_ff   <= req.layer_height;
      end
   end

   // Response outputs.
   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.status      = rs_st_ff;
   assign rsp.layer_count = 6'(cnt_ff);
   assign rsp.in_grid     = rs_sp_ff.placed;
   assign rsp.min_tile_x  = rs_sp_ff.placed ? 3'(rs_sp_ff.x0) : 3'd0;
   assign rsp.max_tile_x  = rs_sp_ff.placed ? 3'(rs_sp_ff.x1) : 3'd0;
   assign rsp.min_tile_y  = rs_sp_ff.placed ? 3'(rs_sp_ff.y0) : 3'd0;
   assign rsp.max_tile_y  = rs_sp_ff.placed ? 3'(rs_sp_ff.y1) : 3'd0;
   assign rsp.cell_layers = 32'(rs_cl_ff);

   // Checks.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountBits'(MaxLayers)) else $error("layer count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request taken while response pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");

endmodule

@@ sv/tblo_div.sv @@
// Restoring divider, one quotient bit a cycle.
module tblo_div
   import tblo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DivBits-1:0] dividend,
   input  logic [15:0]        divisor,
   output logic               done,
   output logic [DivBits-1:0] quotient
);

   logic [DivBits-1:0] q_ff, q_in;
   logic [16:0]        r_ff, r_in;
   logic [4:0]         n_ff, n_in;
   logic               busy_ff, busy_in;
   logic [17:0]        trial;

   // One shift-subtract step per cycle.
   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      trial   = {r_ff, q_ff[DivBits-1]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         n_in    = 5'(DivBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b0, divisor}) begin
            r_in = 17'(trial - {2'b0, divisor});
            q_in = {q_ff[DivBits-2:0], 1'b1};
         end else begin
            r_in = trial[16:0];
            q_in = {q_ff[DivBits-2:0], 1'b0};
         end
         n_in = n_ff - 5'd1;
         if (n_ff == 5'd1)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         n_ff    <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done     = busy_ff && (n_ff == 5'd1);
   assign quotient = done ? q_in : q_ff;

endmodule
